### rtl/mtb_pkg.sv
// Shared constants, command and status types for the markup tag balancer.
`default_nettype none
package mtb_pkg;
  localparam int STACK_DEPTH  = 16;
  localparam int NAME_MAX     = 15;
  localparam int MATCH_WINDOW = 3;

  localparam int IDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int LEN_W  = $clog2(NAME_MAX + 1);
  localparam int COL_W  = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
  localparam int ADDR_W = (STACK_DEPTH * NAME_MAX > 1) ? $clog2(STACK_DEPTH * NAME_MAX) : 1;
  localparam int KK_W   = 2;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {LX_NONE, LX_LT, LX_SLASH, LX_CHAR, LX_TERM, LX_EOI} lex_op_t;
  typedef enum logic [1:0] {CN_NONE, CN_INC, CN_DEC, CN_SUB} cnt_op_t;
  typedef enum logic [1:0] {OS_LIT, OS_CUR, OS_MEM} out_sel_t;
  typedef enum logic [1:0] {PH_PLAIN, PH_AFTER_LT, PH_NAME} phase_t;

  typedef struct packed {
    lex_op_t          lex_op;
    cnt_op_t          cnt_op;
    logic [KK_W-1:0]  sub_amt;
    logic             len_wr;
    logic             st_wr;
    logic             rd_req;
    logic             out_load;
    out_sel_t         out_sel;
    logic [7:0]       lit;
    logic             out_bvalid;
    logic             out_last;
    logic             out_fin;
    logic [IDX_W-1:0] row;
    logic [COL_W-1:0] col;
  } cmd_t;

  typedef struct packed {
    phase_t           phase;
    logic             closing;
    logic [LEN_W-1:0] cur_len;
    logic [CNT_W-1:0] count;
    logic [LEN_W-1:0] row_len;
    logic             single;
    logic             emit_ok;
    logic             char_eq;
  } sts_t;
endpackage
`default_nettype wire

### rtl/mtb_ifs.sv
// Input and result channel interfaces.
`default_nettype none
interface mtb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;
  modport source (output valid, in_byte, end_of_input, input ready);
  modport sink (input valid, in_byte, end_of_input, output ready);
endinterface

interface mtb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last;
  logic       finished;
  modport source (output valid, out_byte, byte_valid, last, finished, input ready);
  modport sink (input valid, out_byte, byte_valid, last, finished, output ready);
endinterface
`default_nettype wire

### rtl/markup_tag_balancer.sv
// Top level: richtext tag balancer with APB-style configuration port.
// Path: a plain byte beat passes the controller's byte register, then the
//   output register; a tag's first byte is loaded from S_T_LT, entered on its
//   terminator or after the close-tag match search (up to 3 names).
// Throughput: input bytes are taken only in the idle state; one output beat
//   per cycle while the output is not stalled for names held in the lexer;
//   stack-store names alternate read and emit states (registered read).
// Reset (rst_n, synchronous, active low): empty stack, plain-text lexer
//   phase, output empty, correction on. Name stores are not cleared.
`default_nettype none
module markup_tag_balancer import mtb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  mtb_in_if.sink           in_ch,
  mtb_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam logic REG_CORRECTION = 1'b0;   // register index 0 at byte 0

  logic corr_r;
  cmd_t cmd;
  sts_t sts;

  // Config register: written on the access phase of an APB write.
  always_ff @(posedge clk) begin
    if (!rst_n) corr_r <= 1'b1;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_CORRECTION)
      corr_r <= cfg_pwdata[0];
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_CORRECTION) ? {31'b0, corr_r} : 32'b0;

  // Controller takes the input beat only when idle; the output register in the
  // datapath lets it do so while a result beat is still waiting.
  mtb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_byte    (in_ch.in_byte),
    .in_eoi     (in_ch.end_of_input),
    .correction (corr_r),
    .sts        (sts),
    .in_ready   (in_ch.ready),
    .cmd        (cmd)
  );

  mtb_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_byte    (in_ch.in_byte),
    .out_ready  (out_ch.ready),
    .sts        (sts),
    .out_valid  (out_ch.valid),
    .out_byte   (out_ch.out_byte),
    .out_bvalid (out_ch.byte_valid),
    .out_last   (out_ch.last),
    .out_fin    (out_ch.finished)
  );
endmodule
`default_nettype wire

### rtl/mtb_dp.sv
// Datapath: lexer registers, name stack, stack count and output register.
`default_nettype none
module mtb_dp import mtb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cmd_t       cmd,
  input  wire logic [7:0] in_byte,
  input  wire logic       out_ready,
  output sts_t            sts,
  output logic            out_valid,
  output logic [7:0]      out_byte,
  output logic            out_bvalid,
  output logic            out_last,
  output logic            out_fin
);
  phase_t           phase_r;
  logic             closing_r;
  logic [LEN_W-1:0] cur_len_r;
  logic [CNT_W-1:0] count_r;
  logic [7:0]       cur_name_r [NAME_MAX];
  logic [LEN_W-1:0] len_r [STACK_DEPTH];
  logic [7:0]       mem [STACK_DEPTH*NAME_MAX];
  logic [7:0]       rd_data_r;
  logic             out_v_r;
  logic [7:0]       out_byte_r;
  logic             out_bv_r, out_last_r, out_fin_r;

  logic [7:0]        lc;
  logic [7:0]        cur_ch;
  logic [7:0]        out_mux;
  logic              single;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  assign lc      = (in_byte >= 8'h41 && in_byte <= 8'h5A) ? in_byte + 8'd32 : in_byte;
  assign cur_ch  = cur_name_r[cmd.col];
  assign wr_addr = ADDR_W'(count_r[IDX_W-1:0]) * ADDR_W'(NAME_MAX) + ADDR_W'(cmd.col);
  assign rd_addr = ADDR_W'(cmd.row) * ADDR_W'(NAME_MAX) + ADDR_W'(cmd.col);

  generate
    if (NAME_MAX >= 2) begin : g_single
      assign single = (cur_len_r == LEN_W'(2)) &&
        ((cur_name_r[0] == 8'h6E && cur_name_r[1] == 8'h6C) ||
         (cur_name_r[0] == 8'h6C && cur_name_r[1] == 8'h74) ||
         (cur_name_r[0] == 8'h6E && cur_name_r[1] == 8'h70));
    end else begin : g_nosingle
      assign single = 1'b0;
    end
  endgenerate

  always_comb begin
    unique case (cmd.out_sel)
      OS_CUR:  out_mux = cur_ch;
      OS_MEM:  out_mux = rd_data_r;
      default: out_mux = cmd.lit;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_PLAIN;
      closing_r <= 1'b0;
      cur_len_r <= '0;
      count_r   <= '0;
      out_v_r   <= 1'b0;
    end else begin
      unique case (cmd.lex_op)
        LX_LT: begin
          phase_r   <= PH_AFTER_LT;
          closing_r <= 1'b0;
          cur_len_r <= '0;
        end
        LX_SLASH: begin
          phase_r   <= PH_NAME;
          closing_r <= 1'b1;
        end
        LX_CHAR: begin
          phase_r <= PH_NAME;
          if (cur_len_r < LEN_W'(NAME_MAX)) cur_len_r <= cur_len_r + 1'b1;
        end
        LX_TERM: phase_r <= PH_PLAIN;
        LX_EOI: begin
          phase_r   <= PH_PLAIN;
          closing_r <= 1'b0;
          cur_len_r <= '0;
        end
        default: ;
      endcase
      unique case (cmd.cnt_op)
        CN_INC:  count_r <= count_r + 1'b1;
        CN_DEC:  count_r <= count_r - 1'b1;
        CN_SUB:  count_r <= count_r - CNT_W'(cmd.sub_amt);
        default: ;
      endcase
      if (cmd.out_load)   out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lex_op == LX_CHAR && cur_len_r < LEN_W'(NAME_MAX))
      cur_name_r[cur_len_r[COL_W-1:0]] <= lc;
    if (cmd.len_wr) len_r[count_r[IDX_W-1:0]] <= cur_len_r;
    if (cmd.st_wr) mem[wr_addr] <= cur_ch;
    if (cmd.rd_req) rd_data_r <= mem[rd_addr];
    if (cmd.out_load) begin
      out_byte_r <= out_mux;
      out_bv_r   <= cmd.out_bvalid;
      out_last_r <= cmd.out_last;
      out_fin_r  <= cmd.out_fin;
    end
  end

  assign sts.phase   = phase_r;
  assign sts.closing = closing_r;
  assign sts.cur_len = cur_len_r;
  assign sts.count   = count_r;
  assign sts.row_len = len_r[cmd.row];
  assign sts.single  = single;
  assign sts.emit_ok = !out_v_r || out_ready;
  assign sts.char_eq = (rd_data_r == cur_ch);

  assign out_valid  = out_v_r;
  assign out_byte   = out_byte_r;
  assign out_bvalid = out_bv_r;
  assign out_last   = out_last_r;
  assign out_fin    = out_fin_r;
endmodule
`default_nettype wire

### rtl/mtb_ctrl.sv
// Controller: lexer decisions, close-tag matching and tag emission sequencing.
`default_nettype none
module mtb_ctrl import mtb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_eoi,
  input  wire logic       correction,
  input  wire sts_t       sts,
  output logic            in_ready,
  output cmd_t            cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_OUT_BYTE, S_OUT_FIN, S_T_LT, S_T_SL, S_T_CH, S_T_RD, S_T_MCH, S_T_GT,
    S_M_LEN, S_M_RD, S_M_CMP
  } state_t;
  typedef enum logic [1:0] {J_SINGLE, J_MMEM, J_MCUR} job_t;

  state_t           state_r, state_nxt;
  job_t             job_r, job_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             close_r, close_nxt, mem_r, mem_nxt, last_r, last_nxt;
  logic             push_r, push_nxt;
  logic [IDX_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [KK_W-1:0]  kk_r, kk_nxt, d_r, d_nxt;

  logic             term, can_next;
  logic [IDX_W-1:0] mrow;
  logic [LEN_W-1:0] name_len;
  state_t           name_start;

  assign term     = (in_byte == CH_GT) || (in_byte == CH_SPACE) ||
                    (in_byte >= 8'd9 && in_byte <= 8'd13);
  assign mrow     = IDX_W'(sts.count - CNT_W'(kk_r));
  assign can_next = (kk_r < KK_W'(MATCH_WINDOW)) && (CNT_W'(kk_r) < sts.count);
  assign name_len = mem_r ? sts.row_len : sts.cur_len;
  assign name_start = (name_len == '0) ? S_T_GT : (mem_r ? S_T_RD : S_T_CH);

  always_comb begin
    state_nxt = state_r; job_nxt = job_r; byte_nxt = byte_r;
    close_nxt = close_r; mem_nxt = mem_r; last_nxt = last_r; push_nxt = push_r;
    row_nxt = row_r; col_nxt = col_r; kk_nxt = kk_r; d_nxt = d_r;
    cmd = '0;
    cmd.lex_op = LX_NONE;
    cmd.cnt_op = CN_NONE;
    cmd.out_sel = OS_LIT;
    cmd.row = row_r;
    cmd.col = col_r;
    in_ready = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_eoi) begin
            cmd.lex_op = LX_EOI;
            if (sts.count != '0) begin
              cmd.cnt_op = CN_DEC;
              row_nxt = IDX_W'(sts.count - 1'b1);
              mem_nxt = 1'b1; close_nxt = 1'b1; last_nxt = 1'b1; push_nxt = 1'b0;
              job_nxt = J_SINGLE;
              state_nxt = S_T_LT;
            end else begin
              state_nxt = S_OUT_FIN;
            end
          end else if (sts.phase == PH_PLAIN) begin
            if (in_byte == CH_LT) cmd.lex_op = LX_LT;
            else begin
              byte_nxt = in_byte;
              state_nxt = S_OUT_BYTE;
            end
          end else if (sts.phase == PH_AFTER_LT && in_byte == CH_SLASH) begin
            cmd.lex_op = LX_SLASH;
          end else if (term) begin
            cmd.lex_op = LX_TERM;
            mem_nxt = 1'b0; last_nxt = 1'b1; push_nxt = 1'b0; job_nxt = J_SINGLE;
            if (!correction) begin
              close_nxt = sts.closing;
              state_nxt = S_T_LT;
            end else if (!sts.closing) begin
              close_nxt = 1'b0;
              push_nxt = !sts.single && (sts.count < CNT_W'(STACK_DEPTH));
              state_nxt = S_T_LT;
            end else if (sts.count != '0) begin
              kk_nxt = KK_W'(1);
              state_nxt = S_M_LEN;
            end
          end else begin
            cmd.lex_op = LX_CHAR;
          end
        end
      end
      S_OUT_BYTE: begin
        if (sts.emit_ok) begin
          cmd.out_load = 1'b1; cmd.lit = byte_r; cmd.out_bvalid = 1'b1;
          cmd.out_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_OUT_FIN: begin
        if (sts.emit_ok) begin
          cmd.out_load = 1'b1; cmd.out_last = 1'b1; cmd.out_fin = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_M_LEN, S_M_RD, S_M_CMP: begin
        cmd.row = mrow;
        if (state_r == S_M_RD) begin
          cmd.rd_req = 1'b1;
          state_nxt = S_M_CMP;
        end else begin
          logic hit, miss;
          hit = 1'b0; miss = 1'b0;
          if (state_r == S_M_LEN) begin
            if (sts.row_len != sts.cur_len) miss = 1'b1;
            else if (sts.cur_len == '0) hit = 1'b1;
            else begin
              col_nxt = '0;
              state_nxt = S_M_RD;
            end
          end else begin
            if (!sts.char_eq) miss = 1'b1;
            else if (LEN_W'(col_r) + 1'b1 == sts.cur_len) hit = 1'b1;
            else begin
              col_nxt = col_r + 1'b1;
              state_nxt = S_M_RD;
            end
          end
          if (miss) begin
            if (can_next) begin
              kk_nxt = kk_r + 1'b1;
              state_nxt = S_M_LEN;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          if (hit) begin
            d_nxt = kk_r; close_nxt = 1'b1; push_nxt = 1'b0;
            state_nxt = S_T_LT;
            if (kk_r == KK_W'(1)) begin
              mem_nxt = 1'b0; last_nxt = 1'b1; job_nxt = J_MCUR;
            end else begin
              mem_nxt = 1'b1; last_nxt = 1'b0; job_nxt = J_MMEM;
              kk_nxt = KK_W'(1);
              row_nxt = IDX_W'(sts.count - 1'b1);
            end
          end
        end
      end
      S_T_LT: begin
        if (sts.emit_ok) begin
          cmd.out_load = 1'b1; cmd.lit = CH_LT; cmd.out_bvalid = 1'b1;
          col_nxt = '0;
          state_nxt = close_r ? S_T_SL : name_start;
        end
      end
      S_T_SL: begin
        if (sts.emit_ok) begin
          cmd.out_load = 1'b1; cmd.lit = CH_SLASH; cmd.out_bvalid = 1'b1;
          state_nxt = name_start;
        end
      end
      S_T_CH: begin
        if (sts.emit_ok) begin
          cmd.out_load = 1'b1; cmd.out_sel = OS_CUR; cmd.out_bvalid = 1'b1;
          cmd.st_wr = push_r;
          if (LEN_W'(col_r) + 1'b1 == sts.cur_len) state_nxt = S_T_GT;
          else col_nxt = col_r + 1'b1;
        end
      end
      S_T_RD: begin
        cmd.rd_req = 1'b1;
        state_nxt = S_T_MCH;
      end
      S_T_MCH: begin
        if (sts.emit_ok) begin
          cmd.out_load = 1'b1; cmd.out_sel = OS_MEM; cmd.out_bvalid = 1'b1;
          if (LEN_W'(col_r) + 1'b1 == sts.row_len) state_nxt = S_T_GT;
          else begin
            col_nxt = col_r + 1'b1;
            state_nxt = S_T_RD;
          end
        end
      end
      S_T_GT: begin
        if (sts.emit_ok) begin
          cmd.out_load = 1'b1; cmd.lit = CH_GT; cmd.out_bvalid = 1'b1;
          cmd.out_last = last_r;
          unique case (job_r)
            J_MMEM: begin
              state_nxt = S_T_LT;
              if (kk_r + 1'b1 < d_r) begin
                kk_nxt = kk_r + 1'b1;
                row_nxt = IDX_W'(sts.count - CNT_W'(kk_r) - 1'b1);
              end else begin
                mem_nxt = 1'b0; last_nxt = 1'b1; job_nxt = J_MCUR;
              end
            end
            J_MCUR: begin
              cmd.cnt_op = CN_SUB;
              cmd.sub_amt = d_r;
              state_nxt = S_IDLE;
            end
            default: begin
              if (push_r) begin
                cmd.len_wr = 1'b1;
                cmd.cnt_op = CN_INC;
              end
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      job_r   <= J_SINGLE;
      close_r <= 1'b0;
      mem_r   <= 1'b0;
      last_r  <= 1'b0;
      push_r  <= 1'b0;
      kk_r    <= '0;
      d_r     <= '0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
      close_r <= close_nxt;
      mem_r   <= mem_nxt;
      last_r  <= last_nxt;
      push_r  <= push_nxt;
      kk_r    <= kk_nxt;
      d_r     <= d_nxt;
    end
    byte_r <= byte_nxt;
    row_r  <= row_nxt;
    col_r  <= col_nxt;
  end
endmodule
`default_nettype wire

### rtl/mtb_checker.sv
// Port-level checker for the tag balancer, bound to the top level.
`default_nettype none
module mtb_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_eoi,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       byte_valid,
  input wire logic       last,
  input wire logic       finished
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result beat dropped");
  a_fin_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && finished |-> last && !byte_valid) else $error("bad finished beat");
  a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid |-> finished && out_byte == 8'h00) else $error("empty beat");
  a_eoi_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_eoi |=> !in_ready) else $error("end beat not serviced");
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("output valid after reset");
endmodule

bind markup_tag_balancer mtb_checker u_mtb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_eoi     (in_ch.end_of_input),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.out_byte),
  .byte_valid (out_ch.byte_valid),
  .last       (out_ch.last),
  .finished   (out_ch.finished)
);
`default_nettype wire
